FILE: rtl/lpms_pkg.sv
// Shared types, register indexes and reset values for the LED pattern sequencer.
// No dependencies; every other file uses this package by scoped names.
package lpms_pkg;

  localparam int LED_W = 4;
  localparam logic [8:0] PWM_WRAP = 9'd255;
  localparam logic [15:0] SINCE_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_CHASE   = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_BREATHE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_CHASE    = 3'd1,
    REG_BLINK    = 3'd2,
    REG_REVERSE  = 3'd3,
    REG_BREATHE  = 3'd4,
    REG_STEP     = 3'd5,
    REG_TABLE    = 3'd6
  } reg_index_t;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;
  localparam logic [1:0] BUTTON_MAX = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_TICK  = 2'd1,
    OP_PRESS = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic       cmd;
    logic [1:0] button;
  } in_item_t;

  typedef struct packed {
    logic [LED_W-1:0] led_bits;
    logic             led0_pwm_active;
    logic [8:0]       pwm_level;
    logic [1:0]       current_mode;
    logic             press_dropped;
  } out_item_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [1:0] button;
  } op_item_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] chase_period_ms;
    logic [15:0] blink_period_ms;
    logic [15:0] reverse_period_ms;
    logic [15:0] breathe_period_ms;
    logic [5:0]  glow_step;
    logic [23:0] transition_table;
  } cfg_t;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] CHASE_RST    = 16'd500;
  localparam logic [15:0] BLINK_RST    = 16'd500;
  localparam logic [15:0] REVERSE_RST  = 16'd250;
  localparam logic [15:0] BREATHE_RST  = 16'd20;
  localparam logic [5:0]  STEP_RST     = 6'd10;
  localparam logic [23:0] TABLE_RST    = 24'd204342;

  // Look up the two-bit next mode for a (mode, button) pair.
  function automatic mode_t next_mode(logic [23:0] trans, mode_t m, logic [1:0] ev);
    logic [3:0] idx;
    logic [4:0] sh;
    idx = {2'b00, m} * 4'd3 + {2'b00, ev};
    sh  = {idx, 1'b0};
    return mode_t'(2'(trans >> sh));
  endfunction

endpackage

FILE: rtl/led_pattern_mode_sequencer.sv
// Four-LED pattern sequencer: one result beat for every input beat.
// An accepted beat enters the op queue; the back end then registers its result on out_data.
// Throughput: one beat per cycle while out_ready stays high, set by the back-end update;
// a two-entry queue decouples the debounce front end from the back end.
// Reset (synchronous): registers to their defaults, mode chase, queues empty.
// Depends on lpms_pkg, lpms_front, lpms_op_queue and lpms_back.
module led_pattern_mode_sequencer #(
  parameter int QUEUE_DEPTH = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpms_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpms_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  lpms_pkg::cfg_t     cfg;
  lpms_pkg::op_item_t front_op;
  lpms_pkg::op_item_t q_head;
  logic               front_push;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms       <= lpms_pkg::DEBOUNCE_RST;
      cfg.chase_period_ms   <= lpms_pkg::CHASE_RST;
      cfg.blink_period_ms   <= lpms_pkg::BLINK_RST;
      cfg.reverse_period_ms <= lpms_pkg::REVERSE_RST;
      cfg.breathe_period_ms <= lpms_pkg::BREATHE_RST;
      cfg.glow_step         <= lpms_pkg::STEP_RST;
      cfg.transition_table  <= lpms_pkg::TABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpms_pkg::REG_DEBOUNCE: cfg.debounce_ms       <= cfg_data[15:0];
        lpms_pkg::REG_CHASE:    cfg.chase_period_ms   <= cfg_data[15:0];
        lpms_pkg::REG_BLINK:    cfg.blink_period_ms   <= cfg_data[15:0];
        lpms_pkg::REG_REVERSE:  cfg.reverse_period_ms <= cfg_data[15:0];
        lpms_pkg::REG_BREATHE:  cfg.breathe_period_ms <= cfg_data[15:0];
        lpms_pkg::REG_STEP:     cfg.glow_step         <= cfg_data[5:0];
        lpms_pkg::REG_TABLE:    cfg.transition_table  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lpms_front u_front (
    .clk         (clk),
    .rst         (rst),
    .debounce_ms (cfg.debounce_ms),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .push        (front_push),
    .op          (front_op)
  );

  lpms_op_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_op),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lpms_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op_valid  (q_not_empty),
    .op        (q_head),
    .op_pop    (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // PWM only drives LED 0 in breathing mode
  a_pwm_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.led0_pwm_active |->
      out_data.current_mode == lpms_pkg::MODE_BREATHE)
    else $error("pwm active outside breathing mode");

  a_pwm_level_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.led0_pwm_active |-> out_data.pwm_level == '0)
    else $error("pwm level nonzero while released");

  a_chase_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.current_mode == lpms_pkg::MODE_CHASE ||
                  out_data.current_mode == lpms_pkg::MODE_REVERSE) |->
      $onehot0(out_data.led_bits))
    else $error("chase mode lights more than one led");

  a_breathe_leds_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.current_mode == lpms_pkg::MODE_BREATHE |->
      out_data.led_bits == '0)
    else $error("led levels set in breathing mode");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("back end popped an empty queue");

endmodule

FILE: rtl/lpms_front.sv
// Front end: takes input beats, runs the press debounce and classifies each beat.
// Uses lpms_pkg; feeds lpms_op_queue.
module lpms_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         debounce_ms,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpms_pkg::in_item_t  in_data,
  input  logic                q_full,
  output logic                push,
  output lpms_pkg::op_item_t  op
);

  logic [15:0] since_press;
  logic [15:0] since_press_next;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    since_press_next = since_press;
    op.kind   = lpms_pkg::OP_NOP;
    op.button = in_data.button;
    if (in_data.cmd == lpms_pkg::CMD_TICK) begin
      op.kind = lpms_pkg::OP_TICK;
      if (since_press != lpms_pkg::SINCE_MAX) begin
        since_press_next = since_press + 16'd1;
      end
    end else if (in_data.button <= lpms_pkg::BUTTON_MAX && since_press > debounce_ms) begin
      // restart the debounce window even if the queue later drops it
      op.kind = lpms_pkg::OP_PRESS;
      since_press_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_press <= '0;
    end else if (push) begin
      since_press <= since_press_next;
    end
  end

endmodule

FILE: rtl/lpms_op_queue.sv
// Two-entry queue of classified beats between the front end and the back end.
// Uses lpms_pkg for the entry type.
module lpms_op_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lpms_pkg::op_item_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output lpms_pkg::op_item_t head
);

  lpms_pkg::op_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/lpms_back.sv
// Back end: executes ticks and presses, owns the mode state, the event queue
// memory and the output register. Uses lpms_pkg.
module lpms_back #(
  parameter int QUEUE_DEPTH = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  lpms_pkg::cfg_t      cfg,
  input  logic                op_valid,
  input  lpms_pkg::op_item_t  op,
  output logic                op_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lpms_pkg::out_item_t out_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lpms_pkg::mode_t  mode, mode_next;
  logic [15:0]      wait_count, wait_count_next;
  logic             first_pass, first_pass_next;
  logic [1:0]       chase_idx, chase_idx_next;
  logic             blink_on, blink_on_next;
  logic [1:0]       rev_idx, rev_idx_next;
  logic [8:0]       brightness, brightness_next;
  logic             rising, rising_next;
  logic [lpms_pkg::LED_W-1:0] led_out, led_out_next;
  logic             pwm_on, pwm_on_next;
  logic [8:0]       level, level_next;

  logic [1:0]       ev_mem [QUEUE_DEPTH];
  logic [1:0]       head_data;
  logic [PTR_W-1:0] head, tail, rd_addr;
  logic [CNT_W-1:0] ev_count;

  logic             ev_push, ev_pop, dropped, run_step;
  logic [15:0]      wait_inc, period;
  lpms_pkg::mode_t  new_mode;
  logic [8:0]       step_ext, sum;
  lpms_pkg::out_item_t result;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign op_pop   = op_valid && (!out_valid || out_ready);
  assign wait_inc = wait_count + 16'd1;
  assign step_ext = {3'b000, cfg.glow_step};
  assign sum      = brightness + step_ext;
  assign new_mode = lpms_pkg::next_mode(cfg.transition_table, mode, head_data);

  always_comb begin
    unique case (mode)
      lpms_pkg::MODE_CHASE:   period = cfg.chase_period_ms;
      lpms_pkg::MODE_BLINK:   period = cfg.blink_period_ms;
      lpms_pkg::MODE_REVERSE: period = cfg.reverse_period_ms;
      lpms_pkg::MODE_BREATHE: period = cfg.breathe_period_ms;
      default:                period = cfg.chase_period_ms;
    endcase
  end

  always_comb begin
    mode_next       = mode;
    wait_count_next = wait_count;
    first_pass_next = first_pass;
    chase_idx_next  = chase_idx;
    blink_on_next   = blink_on;
    rev_idx_next    = rev_idx;
    brightness_next = brightness;
    rising_next     = rising;
    led_out_next    = led_out;
    pwm_on_next     = pwm_on;
    level_next      = level;
    ev_push  = 1'b0;
    ev_pop   = 1'b0;
    dropped  = 1'b0;
    run_step = 1'b0;

    case (op.kind)
      lpms_pkg::OP_TICK: begin
        if (first_pass) begin
          first_pass_next = 1'b0;
          wait_count_next = '0;
          run_step = 1'b1;
        end else if (wait_inc >= period) begin
          wait_count_next = '0;
          run_step = 1'b1;
          if (ev_count != '0) begin
            // leave the old mode, take the next one and enter it
            ev_pop = 1'b1;
            led_out_next = '0;
            if (mode == lpms_pkg::MODE_BREATHE) begin
              pwm_on_next = 1'b0;
              level_next  = '0;
            end
            mode_next = new_mode;
            if (new_mode == lpms_pkg::MODE_BREATHE) begin
              pwm_on_next = 1'b1;
              level_next  = '0;
            end
          end
        end else begin
          wait_count_next = wait_inc;
        end
      end
      lpms_pkg::OP_PRESS: begin
        if (ev_count < CNT_W'(QUEUE_DEPTH)) begin
          ev_push = 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (run_step) begin
      unique case (mode_next)
        lpms_pkg::MODE_CHASE: begin
          led_out_next   = lpms_pkg::LED_W'(1) << chase_idx;
          chase_idx_next = chase_idx + 2'd1;
        end
        lpms_pkg::MODE_BLINK: begin
          led_out_next  = blink_on ? '0 : '1;
          blink_on_next = !blink_on;
        end
        lpms_pkg::MODE_REVERSE: begin
          led_out_next = lpms_pkg::LED_W'(1) << rev_idx;
          rev_idx_next = rev_idx - 2'd1;
        end
        lpms_pkg::MODE_BREATHE: begin
          level_next = brightness;
          if (rising) begin
            brightness_next = sum;
            if (sum >= lpms_pkg::PWM_WRAP) begin
              rising_next = 1'b0;
            end
          end else begin
            // saturate at zero instead of wrapping
            brightness_next = (brightness > step_ext) ? brightness - step_ext : '0;
            if (brightness <= step_ext) begin
              rising_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    result.led_bits        = led_out_next;
    result.led0_pwm_active = pwm_on_next;
    result.pwm_level       = pwm_on_next ? level_next : '0;
    result.current_mode    = mode_next;
    result.press_dropped   = dropped;
  end

  // Event queue: circular buffer with the head entry prefetched.
  // Advance the read address only when the pop really happens.
  assign rd_addr = (op_pop && ev_pop) ? ptr_inc(head) : head;

  always_ff @(posedge clk) begin
    if (op_pop && ev_push) begin
      ev_mem[tail] <= op.button;
    end
    if (op_pop && ev_push && tail == rd_addr) begin
      head_data <= op.button;
    end else begin
      head_data <= ev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      ev_count <= '0;
    end else if (op_pop) begin
      if (ev_push) begin
        tail     <= ptr_inc(tail);
        ev_count <= ev_count + 1'b1;
      end
      if (ev_pop) begin
        head     <= rd_addr;
        ev_count <= ev_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= lpms_pkg::MODE_CHASE;
      wait_count <= '0;
      first_pass <= 1'b1;
      chase_idx  <= 2'd0;
      blink_on   <= 1'b0;
      rev_idx    <= 2'd3;
      brightness <= '0;
      rising     <= 1'b1;
      led_out    <= '0;
      pwm_on     <= 1'b0;
      level      <= '0;
    end else if (op_pop) begin
      mode       <= mode_next;
      wait_count <= wait_count_next;
      first_pass <= first_pass_next;
      chase_idx  <= chase_idx_next;
      blink_on   <= blink_on_next;
      rev_idx    <= rev_idx_next;
      brightness <= brightness_next;
      rising     <= rising_next;
      led_out    <= led_out_next;
      pwm_on     <= pwm_on_next;
      level      <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      out_data <= result;
    end
  end

endmodule
